// ----- rtl/p2d_pkg.sv -----
// ----------------------------------------------------------------------------
// p2d_pkg
// shared types and constants of the 2-d pooling block
// ----------------------------------------------------------------------------
`default_nettype none
package p2d_pkg;
	localparam int unsigned SampleW = 16;
	localparam int unsigned ColW    = 8;
	localparam int unsigned RowW    = 8;
	localparam int unsigned ChanW   = 6;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 9;

	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_CHAN   = 3'd2,
		REG_WINDOW = 3'd3,
		REG_STEP   = 3'd4,
		REG_MODE   = 3'd5
	} reg_idx_t;

	localparam logic MODE_MAX = 1'b0;
	localparam logic MODE_AVG = 1'b1;

	// window job handed from the position tracker to the window engine
	typedef struct packed {
		logic [ColW-1:0]  out_col;
		logic [RowW-1:0]  out_row;
		logic [ChanW-1:0] out_chan;
		logic             last;
	} job_tag_t;
endpackage
`default_nettype wire

// ----- rtl/p2d_if.sv -----
// ----------------------------------------------------------------------------
// p2d_in_if / p2d_out_if
// valid-ready channels of the pooling block
// ----------------------------------------------------------------------------
`default_nettype none
interface p2d_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [p2d_pkg::SampleW-1:0] sample;
	logic                               frame_start;
	modport source (output valid, sample, frame_start, input ready);
	modport sink   (input valid, sample, frame_start, output ready);
endinterface

interface p2d_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [p2d_pkg::SampleW-1:0] pooled;
	logic [p2d_pkg::ColW-1:0]           out_col;
	logic [p2d_pkg::RowW-1:0]           out_row;
	logic [p2d_pkg::ChanW-1:0]          out_chan;
	logic                               last_result;
	modport source (output valid, pooled, out_col, out_row, out_chan, last_result,
		input ready);
	modport sink   (input valid, pooled, out_col, out_row, out_chan, last_result,
		output ready);
endinterface
`default_nettype wire

// ----- rtl/p2d_line_ram.sv -----
// ----------------------------------------------------------------------------
// p2d_line_ram
// line store: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module p2d_line_ram #(
	parameter int unsigned AW = 16
) (
	input  wire                               clk,
	input  wire                               we,
	input  wire [AW-1:0]                      waddr,
	input  wire [p2d_pkg::SampleW-1:0]        wdata,
	input  wire                               re,
	input  wire [AW-1:0]                      raddr,
	output logic [p2d_pkg::SampleW-1:0]       rdata
);
	logic [p2d_pkg::SampleW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- rtl/pool_2d_max_avg.sv -----
// ----------------------------------------------------------------------------
// pool_2d_max_avg
// streaming 2-d max / average pooling over a line store memory
// ----------------------------------------------------------------------------
// A sample that completes no window only updates the position and the line
// store. A sample that completes a window is written, then the window's p*p
// entries are read from the single read port of the line store one per cycle;
// average mode adds a division state for the division by p*p, done as a
// shift or a reciprocal multiply. The next request is accepted once the
// result sits in the output register and the output is not stalled.
`default_nettype none
module pool_2d_max_avg #(
	parameter int unsigned MAX_WIDTH    = 256,
	parameter int unsigned MAX_HEIGHT   = 256,
	parameter int unsigned MAX_CHANNELS = 64,
	parameter int unsigned MAX_POOL     = 4
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [p2d_pkg::CfgIdxW-1:0]       cfg_index,
	input  wire [p2d_pkg::CfgDataW-1:0]      cfg_data,
	p2d_in_if.sink                           in_ch,
	p2d_out_if.source                        out_ch
);
	localparam int unsigned XW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int unsigned PW  = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;
	localparam int unsigned AW  = PW + XW + CW;
	localparam int unsigned SUMW = 23;

	typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_ACC, ST_DIV, ST_OUT} state_t;

	logic [8:0] width_q, height_q;
	logic [6:0] chans_q;
	logic [2:0] win_q, step_q;
	logic       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 9'd8; height_q <= 9'd8; chans_q <= 7'd1;
			win_q <= 3'd2; step_q <= 3'd2; mode_q <= p2d_pkg::MODE_MAX;
		end else if (cfg_we) begin
			case (cfg_index)
				p2d_pkg::REG_WIDTH:  width_q  <= cfg_data;
				p2d_pkg::REG_HEIGHT: height_q <= cfg_data;
				p2d_pkg::REG_CHAN:   chans_q  <= cfg_data[6:0];
				p2d_pkg::REG_WINDOW: win_q    <= cfg_data[2:0];
				p2d_pkg::REG_STEP:   step_q   <= cfg_data[2:0];
				p2d_pkg::REG_MODE:   mode_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective (clamped) settings
	logic [12:0] w_e, h_e;
	logic [10:0] nc_e;
	logic [3:0]  p_e;
	logic [2:0]  s_e;
	always_comb begin
		w_e  = (width_q == 0) ? 13'd1 : (13'(width_q) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH)
			: 13'(width_q);
		h_e  = (height_q == 0) ? 13'd1 : (13'(height_q) > 13'(MAX_HEIGHT))
			? 13'(MAX_HEIGHT) : 13'(height_q);
		nc_e = (chans_q == 0) ? 11'd1 : (11'(chans_q) > 11'(MAX_CHANNELS))
			? 11'(MAX_CHANNELS) : 11'(chans_q);
		p_e  = (win_q == 0) ? 4'd1 : (4'(win_q) > 4'(MAX_POOL)) ? 4'(MAX_POOL) : 4'(win_q);
		s_e  = (step_q == 0) ? 3'd1 : step_q;
	end

	state_t state_q;
	logic [12:0] col_q, row_q;
	logic [10:0] chan_q;

	wire accept = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_ch.valid ||
		(state_q == ST_IDLE && out_ch.ready);

	logic [12:0] c, r;
	logic [10:0] ch;
	always_comb begin
		c = in_ch.frame_start ? 13'd0 : col_q;
		r = in_ch.frame_start ? 13'd0 : row_q;
		ch = in_ch.frame_start ? 11'd0 : chan_q;
	end

	logic c_ok, r_ok;
	assign c_ok = (c + 13'd1 >= 13'(p_e));
	assign r_ok = (r + 13'd1 >= 13'(p_e));

	// v/s for s in 1..7 by reciprocal multiply, exact for any 13-bit v
	function automatic logic [12:0] div_s(input logic [12:0] v, input logic [2:0] s);
		logic [28:0] prod;
		logic [12:0] q;
		prod = '0;
		q = v;
		case (s)
			3'd1: q = v;
			3'd2: q = v >> 1;
			3'd4: q = v >> 2;
			3'd3: begin prod = 29'(v) * 29'd21846; q = prod[28:16]; end
			3'd5: begin prod = 29'(v) * 29'd13108; q = prod[28:16]; end
			3'd6: begin prod = 29'(v) * 29'd10923; q = prod[28:16]; end
			3'd7: begin prod = 29'(v) * 29'd9363;  q = prod[28:16]; end
			default: q = v;
		endcase
		return q;
	endfunction

	// output size
	logic [12:0] ow_m1, oh_m1;
	logic [12:0] wd, hd;
	assign wd = w_e - 13'(p_e);
	assign hd = h_e - 13'(p_e);
	assign ow_m1 = div_s(wd, s_e);
	assign oh_m1 = div_s(hd, s_e);

	// window origin of this sample and its output indices
	logic [12:0] oc, orw, x, y;
	assign oc  = c + 13'd1 - 13'(p_e);
	assign orw = r + 13'd1 - 13'(p_e);
	assign x = div_s(oc, s_e);
	assign y = div_s(orw, s_e);
	wire on_step = (oc == 13'(x * 13'(s_e))) && (orw == 13'(y * 13'(s_e)));

	wire fires = (13'(p_e) <= w_e) && (13'(p_e) <= h_e) && c_ok && r_ok && on_step
		&& x <= ow_m1 && y <= oh_m1 && ch < nc_e;

	// next position
	logic [12:0] c_n, r_n;
	logic [10:0] ch_n;
	always_comb begin
		c_n = c; r_n = r; ch_n = ch + 11'd1;
		if (ch_n >= nc_e) begin
			ch_n = 11'd0;
			c_n = c + 13'd1;
			if (c_n >= w_e) begin
				c_n = 13'd0;
				r_n = r + 13'd1;
				if (r_n >= h_e) r_n = 13'd0;
			end
		end
	end

	// row slot is the row's low bits, at least MAX_POOL rows deep
	function automatic logic [AW-1:0] addr_of(input logic [12:0] rr, input logic [12:0] cc,
		input logic [10:0] hh);
		return {rr[PW-1:0], cc[XW-1:0], hh[CW-1:0]};
	endfunction

	logic [12:0] x0_q, y0_q;
	logic [10:0] jch_q;
	logic [3:0]  px_q, py_q;
	logic        first_q, rd_v_q;
	logic signed [SUMW-1:0] sum_q;
	logic signed [p2d_pkg::SampleW-1:0] best_q;
	p2d_pkg::job_tag_t tag_q;
	logic [SUMW-1:0] dq_q;
	logic neg_q;

	wire rd_en = (state_q == ST_READ);
	wire [AW-1:0] raddr = addr_of(y0_q + 13'(py_q), x0_q + 13'(px_q), jch_q);
	logic [p2d_pkg::SampleW-1:0] rdata;

	p2d_line_ram #(.AW(AW)) u_ram (
		.clk(clk), .we(accept), .waddr(addr_of(r, c, ch)), .wdata(in_ch.sample),
		.re(rd_en), .raddr(raddr), .rdata(rdata)
	);

	wire last_rd = (px_q == p_e - 4'd1) && (py_q == p_e - 4'd1);
	wire signed [p2d_pkg::SampleW-1:0] v = $signed(rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			col_q <= 0; row_q <= 0; chan_q <= 0;
			out_ch.valid <= 1'b0;
			rd_v_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!out_ch.valid || out_ch.ready)) out_ch.valid <= 1'b1;
			else if (out_ch.ready) out_ch.valid <= 1'b0;
			rd_v_q <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						col_q <= c_n; row_q <= r_n; chan_q <= ch_n;
						if (fires) begin
							x0_q <= oc;
							y0_q <= orw;
							jch_q <= ch;
							px_q <= 0; py_q <= 0; first_q <= 1'b1;
							sum_q <= 0;
							tag_q.out_col <= x[7:0];
							tag_q.out_row <= y[7:0];
							tag_q.out_chan <= ch[5:0];
							tag_q.last <= (x == ow_m1) && (y == oh_m1) && (ch == nc_e - 11'd1);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					if (px_q == p_e - 4'd1) begin px_q <= 0; py_q <= py_q + 4'd1; end
					else px_q <= px_q + 4'd1;
					if (last_rd) state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!rd_v_q) begin
						if (mode_q == p2d_pkg::MODE_AVG) begin
							neg_q <= sum_q[SUMW-1];
							dq_q <= sum_q[SUMW-1] ? SUMW'(-sum_q) : SUMW'(sum_q);
							state_q <= ST_DIV;
						end else state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					// magnitude / (p*p), reciprocal scaled by 2^28
					case (p_e)
						4'd1: dq_q <= dq_q;
						4'd2: dq_q <= dq_q >> 2;
						4'd4: dq_q <= dq_q >> 4;
						4'd3: dq_q <= SUMW'((48'(dq_q) * 48'd29826162) >> 28);
						4'd5: dq_q <= SUMW'((48'(dq_q) * 48'd10737419) >> 28);
						4'd6: dq_q <= SUMW'((48'(dq_q) * 48'd7456541) >> 28);
						4'd7: dq_q <= SUMW'((48'(dq_q) * 48'd5478275) >> 28);
						default: dq_q <= dq_q;
					endcase
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_ch.valid || out_ch.ready) begin
						out_ch.pooled <= (mode_q == p2d_pkg::MODE_AVG)
							? (neg_q ? -$signed(dq_q[15:0]) : $signed(dq_q[15:0])) : best_q;
						out_ch.out_col <= tag_q.out_col;
						out_ch.out_row <= tag_q.out_row;
						out_ch.out_chan <= tag_q.out_chan;
						out_ch.last_result <= tag_q.last;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (rd_v_q) begin
				sum_q <= sum_q + SUMW'(v);
				first_q <= 1'b0;
				if (first_q || v > best_q) best_q <= v;
			end
		end
	end

	property p_no_accept_busy;
		@(posedge clk) disable iff (!arst_n) (state_q != ST_IDLE) |-> !in_ch.ready;
	endproperty
	a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> $stable(out_ch.pooled))
		else $error("result changed while stalled");

	a_read_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ && last_rd) |=> state_q == ST_ACC)
		else $error("window read sweep did not finish");
endmodule
`default_nettype wire

// ----- sim/pool_2d_max_avg_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pool_2d_max_avg_checker
// Watches the register port and both channels of the pooling block. It keeps
// its own line store, position and registers, works out the pooled result
// that each accepted sample causes, and compares every result field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module pool_2d_max_avg_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [p2d_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire [p2d_pkg::CfgDataW-1:0] cfg_data,
	p2d_in_if                           in_ch,
	p2d_out_if                          out_ch,
	output int                          fail_count,
	output int                          pending
);
	typedef struct {
		logic signed [15:0] pooled;
		logic [7:0]         col;
		logic [7:0]         row;
		logic [5:0]         chan;
		logic               last;
	} window_result_t;

	window_result_t result_q[$];
	logic signed [15:0] line_mem [0:65535];

	logic [8:0] r_width, r_height;
	logic [6:0] r_chans;
	logic [2:0] r_window, r_step;
	logic       r_mode;
	int col_pos, row_pos, chan_pos;

	function automatic int clamp_to(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int mem_addr(int row, int col, int ch);
		return ((row % 4) * 256 + (col % 256)) * 64 + (ch % 64);
	endfunction

	task automatic take_sample(logic signed [15:0] smp, logic fs);
		int w, h, nc, p, s, ow, oh, x, y, sum, best, v;
		window_result_t res;
		w  = clamp_to(r_width, 256);
		h  = clamp_to(r_height, 256);
		nc = clamp_to(r_chans, 64);
		p  = clamp_to(r_window, 4);
		s  = (r_step == 0) ? 1 : r_step;
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
			chan_pos = 0;
		end
		line_mem[mem_addr(row_pos, col_pos, chan_pos)] = smp;
		if (p <= w && p <= h && col_pos + 1 >= p && row_pos + 1 >= p
				&& (col_pos + 1 - p) % s == 0 && (row_pos + 1 - p) % s == 0) begin
			ow = (w - p) / s + 1;
			oh = (h - p) / s + 1;
			x = (col_pos + 1 - p) / s;
			y = (row_pos + 1 - p) / s;
			if (x < ow && y < oh && chan_pos < nc) begin
				sum = 0;
				best = line_mem[mem_addr(row_pos + 1 - p, col_pos + 1 - p, chan_pos)];
				for (int py = row_pos + 1 - p; py <= row_pos; py++) begin
					for (int px = col_pos + 1 - p; px <= col_pos; px++) begin
						v = line_mem[mem_addr(py, px, chan_pos)];
						if (v > best) best = v;
						sum += v;
					end
				end
				res.pooled = (r_mode == p2d_pkg::MODE_AVG) ? 16'(sum / (p * p)) : 16'(best);
				res.col  = x[7:0];
				res.row  = y[7:0];
				res.chan = chan_pos[5:0];
				res.last = (x == ow - 1 && y == oh - 1 && chan_pos == nc - 1);
				result_q.push_back(res);
			end
		end
		chan_pos++;
		if (chan_pos >= nc) begin
			chan_pos = 0;
			col_pos++;
			if (col_pos >= w) begin
				col_pos = 0;
				row_pos++;
				if (row_pos >= h) row_pos = 0;
			end
		end
	endtask

	task automatic check_result();
		window_result_t exp_r;
		if (result_q.size() == 0) begin
			$display("%0t: unexpected result pooled=%0d col=%0d row=%0d chan=%0d", $time,
				out_ch.pooled, out_ch.out_col, out_ch.out_row, out_ch.out_chan);
			fail_count++;
			return;
		end
		exp_r = result_q.pop_front();
		if (out_ch.pooled !== exp_r.pooled || out_ch.out_col !== exp_r.col
				|| out_ch.out_row !== exp_r.row || out_ch.out_chan !== exp_r.chan
				|| out_ch.last_result !== exp_r.last) begin
			$display("%0t: mismatch expected pooled=%0d col=%0d row=%0d chan=%0d last=%0d",
				$time, exp_r.pooled, exp_r.col, exp_r.row, exp_r.chan, exp_r.last);
			$display("%0t:          actual   pooled=%0d col=%0d row=%0d chan=%0d last=%0d",
				$time, out_ch.pooled, out_ch.out_col, out_ch.out_row, out_ch.out_chan,
				out_ch.last_result);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_width <= 9'd8;
			r_height <= 9'd8;
			r_chans <= 7'd1;
			r_window <= 3'd2;
			r_step <= 3'd2;
			r_mode <= p2d_pkg::MODE_MAX;
			col_pos = 0;
			row_pos = 0;
			chan_pos = 0;
			fail_count = 0;
			result_q.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				case (p2d_pkg::reg_idx_t'(cfg_index))
					p2d_pkg::REG_WIDTH:  r_width <= cfg_data;
					p2d_pkg::REG_HEIGHT: r_height <= cfg_data;
					p2d_pkg::REG_CHAN:   r_chans <= cfg_data[6:0];
					p2d_pkg::REG_WINDOW: r_window <= cfg_data[2:0];
					p2d_pkg::REG_STEP:   r_step <= cfg_data[2:0];
					p2d_pkg::REG_MODE:   r_mode <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) take_sample(in_ch.sample, in_ch.frame_start);
			if (out_ch.valid && out_ch.ready) check_result();
			pending = result_q.size();
		end
	end
endmodule
`default_nettype wire

// ----- sim/pool_2d_max_avg_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pool_2d_max_avg_tb
// Streams whole images through the pooling block under many register
// settings, with random gaps and output stalls, and reports the verdict.
// ----------------------------------------------------------------------------
`default_nettype none
module pool_2d_max_avg_tb;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [p2d_pkg::CfgIdxW-1:0] cfg_index;
	logic [p2d_pkg::CfgDataW-1:0] cfg_data;
	int fail_count, pending;
	int cycle_count = 0;
	int samples_sent = 0;
	bit quiet = 1'b0;

	p2d_in_if in_ch ();
	p2d_out_if out_ch ();

	pool_2d_max_avg dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
	);

	pool_2d_max_avg_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[pool_2d_max_avg] ERROR");
			$finish;
		end
	end

	// output stalls in bursts
	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	function automatic int clamp_to(int v, int hi);
		if (v < 1) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic send_sample(logic signed [15:0] smp, logic fs);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= smp;
		in_ch.frame_start <= fs;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		samples_sent++;
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// writes all registers with raw values, then streams images;
	// sample_kind: 0 random, 1 extremes
	task automatic run_setting(int w, int h, int nc, int p, int s, int mode, int images,
			int sample_kind);
		int ew, eh, enc, total;
		logic signed [15:0] smp;
		logic fs;
		wait_idle();
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[p2d_pkg::CfgIdxW-1:0];
			case (p2d_pkg::reg_idx_t'(i))
				p2d_pkg::REG_WIDTH:  cfg_data <= w[8:0];
				p2d_pkg::REG_HEIGHT: cfg_data <= h[8:0];
				p2d_pkg::REG_CHAN:   cfg_data <= p2d_pkg::CfgDataW'(nc[6:0]);
				p2d_pkg::REG_WINDOW: cfg_data <= p2d_pkg::CfgDataW'(p[2:0]);
				p2d_pkg::REG_STEP:   cfg_data <= p2d_pkg::CfgDataW'(s[2:0]);
				default:             cfg_data <= p2d_pkg::CfgDataW'(mode[0]);
			endcase
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		ew = clamp_to(w[8:0], 256);
		eh = clamp_to(h[8:0], 256);
		enc = clamp_to(nc[6:0], 64);
		total = ew * eh * enc;
		for (int img = 0; img < images; img++) begin
			for (int k = 0; k < total; k++) begin
				if (sample_kind == 1) begin
					case ($urandom_range(0, 3))
						0: smp = 16'sh8000;
						1: smp = 16'sh7fff;
						2: smp = 16'sh0000;
						default: smp = 16'shffff;
					endcase
				end else begin
					smp = 16'($urandom);
				end
				if (k == 0) fs = (img == 0) || $urandom_range(0, 1);
				else fs = 1'b0;
				// occasional broken image: restart part way through
				if (k != 0 && $urandom_range(0, 60) == 0) begin
					fs = 1'b1;
					k = 0;
				end
				send_sample(smp, fs);
			end
		end
	endtask

	initial begin
		int w, h, nc, p, s;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_ch.valid <= 1'b0;
		in_ch.sample <= '0;
		in_ch.frame_start <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of samples in both modes, window equal to image
		run_setting(2, 2, 1, 2, 2, p2d_pkg::MODE_MAX, 3, 1);
		run_setting(2, 2, 1, 2, 2, p2d_pkg::MODE_AVG, 3, 1);
		run_setting(3, 3, 1, 3, 3, p2d_pkg::MODE_AVG, 2, 1);
		run_setting(4, 4, 1, 4, 4, p2d_pkg::MODE_AVG, 1, 1);
		// window larger than image
		run_setting(3, 5, 1, 4, 1, p2d_pkg::MODE_MAX, 1, 0);
		// register extremes and out of range values
		run_setting(0, 0, 0, 0, 0, p2d_pkg::MODE_AVG, 1, 0);
		run_setting(1, 1, 127, 1, 2, p2d_pkg::MODE_MAX, 1, 0);
		run_setting(6, 4, 1, 7, 7, p2d_pkg::MODE_AVG, 1, 0);

		while (samples_sent < 450) begin
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			nc = $urandom_range(1, 3);
			p = $urandom_range(1, 4);
			s = $urandom_range(1, 4);
			if ($urandom_range(0, 7) == 0) s = 0;
			if ($urandom_range(0, 7) == 0) p = $urandom_range(5, 7);
			if (samples_sent > 350) quiet = 1'b1;
			run_setting(w, h, nc, p, s, $urandom_range(0, 1), $urandom_range(1, 2), 0);
		end
		quiet = 1'b1;
		wait_idle();

		if (fail_count == 0) begin
			$display("[pool_2d_max_avg] OK");
		end else begin
			$display("[pool_2d_max_avg] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
